// ===== src/fbx_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbx_pkg
// Shared types, sizes and an index helper for the filter bytecode execute unit.
// ----------------------------------------------------------------------------
package fbx_pkg;

   localparam int unsigned FBX_NUM_REGS = 8;
   localparam int unsigned FBX_NUM_ACCS = 4;

   // instruction modes
   typedef enum logic [4:0] {
      MODE_LD64   = 5'd0,
      MODE_LDU16  = 5'd1,
      MODE_LDI16  = 5'd2,
      MODE_LDU32  = 5'd3,
      MODE_LDI32  = 5'd4,
      MODE_LDCOL  = 5'd5,
      MODE_MOV    = 5'd6,
      MODE_ADD    = 5'd7,
      MODE_SUB    = 5'd8,
      MODE_MUL    = 5'd9,
      MODE_ACCSUM = 5'd10,
      MODE_BLT    = 5'd11,
      MODE_BLE    = 5'd12,
      MODE_BEQ    = 5'd13,
      MODE_BGT    = 5'd14,
      MODE_BGE    = 5'd15,
      MODE_BNE    = 5'd16
   } fbx_mode_type;

   // one instruction word
   typedef struct packed {
      logic [4:0]         mode;
      logic [2:0]         dest_index;
      logic [2:0]         src_a_index;
      logic [2:0]         src_b_index;
      logic signed [63:0] immediate;
      logic signed [63:0] column_value;
   } fbx_req_type;

   // one result word
   typedef struct packed {
      logic               branch_taken;
      logic signed [63:0] written_value;
      logic               did_write;
   } fbx_rsp_type;

   // execute stage outcome, multiply kept as partial products
   typedef struct packed {
      logic [63:0] val;
      logic        taken;
      logic        wr_reg;
      logic        wr_acc;
      logic        is_mul;
      logic [63:0] pp_ll;
      logic [31:0] pp_lh;
      logic [31:0] pp_hl;
   } fbx_alu_out_type;

   // wraps a 3-bit index into 0 .. modulus-1 by repeated subtraction
   function automatic logic [2:0] fbx_wrap_index(input logic [2:0] idx,
                                                input int unsigned modulus);
      logic [2:0] v;
      v = idx;
      for (int i = 0; i < 8; i++) begin
         if ({29'd0, v} >= modulus) begin
            v = v - modulus[2:0];
         end
      end
      return v;
   endfunction

endpackage

// ===== src/fbx_regfile.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbx_regfile
// General register memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module fbx_regfile #(
   parameter int unsigned DEPTH = 8,
   parameter int unsigned AW    = 3
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [63:0]   wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr_a,
   input  logic [AW-1:0] raddr_b,
   output logic [63:0]   rdata_a,
   output logic [63:0]   rdata_b
);

   logic [63:0] mem [DEPTH];
   logic [63:0] rdata_a_ff;
   logic [63:0] rdata_b_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read data only moves when a new word is taken
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_a_ff <= mem[raddr_a];
         rdata_b_ff <= mem[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

// ===== src/fbx_accfile.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbx_accfile
// Accumulator memory with per-slot valid bits; unwritten slots read as zero.
// ----------------------------------------------------------------------------
module fbx_accfile #(
   parameter int unsigned DEPTH = 4,
   parameter int unsigned AW    = 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [63:0]   wdata,
   input  logic          re,
   input  logic [AW-1:0] raddr,
   output logic [63:0]   rdata
);

   logic [63:0]    mem [DEPTH];
   logic [DEPTH-1:0] vld_ff;
   logic [DEPTH-1:0] vld_in;
   logic [63:0]    rdata_ff;
   logic           rvld_ff;

   always_comb begin
      vld_in = vld_ff;
      if (we) begin
         vld_in[waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem[raddr];
         rvld_ff  <= vld_ff[raddr];
      end
   end

   assign rdata = rvld_ff ? rdata_ff : 64'd0;

endmodule

// ===== src/fbx_alu.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbx_alu
// Execute logic: loads, move, add, subtract, accumulate, compares, and the
// partial products of the 64-bit multiply.
// ----------------------------------------------------------------------------
module fbx_alu (
   input  logic [4:0]              mode,
   input  logic [63:0]             opa,
   input  logic [63:0]             opb,
   input  logic [63:0]             acc,
   input  logic [63:0]             imm,
   input  logic [63:0]             col,
   output fbx_pkg::fbx_alu_out_type res
);

   import fbx_pkg::*;

   logic [31:0] a_lo;
   logic [31:0] a_hi;
   logic [31:0] b_lo;
   logic [31:0] b_hi;
   logic        a_lt_b;
   logic        b_lt_a;

   assign a_lo   = opa[31:0];
   assign a_hi   = opa[63:32];
   assign b_lo   = opb[31:0];
   assign b_hi   = opb[63:32];
   assign a_lt_b = $signed(opa) < $signed(opb);
   assign b_lt_a = $signed(opb) < $signed(opa);

   always_comb begin
      res        = '0;
      // only the low half of the cross products reaches the 64-bit result
      res.pp_ll  = a_lo * b_lo;
      res.pp_lh  = a_lo * b_hi;
      res.pp_hl  = a_hi * b_lo;
      case (mode)
         MODE_LD64: begin
            res.val    = imm;
            res.wr_reg = 1'b1;
         end
         MODE_LDU16: begin
            res.val    = {48'd0, imm[15:0]};
            res.wr_reg = 1'b1;
         end
         MODE_LDI16: begin
            res.val    = {{48{imm[15]}}, imm[15:0]};
            res.wr_reg = 1'b1;
         end
         MODE_LDU32: begin
            res.val    = {32'd0, imm[31:0]};
            res.wr_reg = 1'b1;
         end
         MODE_LDI32: begin
            res.val    = {{32{imm[31]}}, imm[31:0]};
            res.wr_reg = 1'b1;
         end
         MODE_LDCOL: begin
            res.val    = col;
            res.wr_reg = 1'b1;
         end
         MODE_MOV: begin
            res.val    = opa;
            res.wr_reg = 1'b1;
         end
         MODE_ADD: begin
            res.val    = opa + opb;
            res.wr_reg = 1'b1;
         end
         MODE_SUB: begin
            res.val    = opa - opb;
            res.wr_reg = 1'b1;
         end
         MODE_MUL: begin
            res.wr_reg = 1'b1;
            res.is_mul = 1'b1;
         end
         MODE_ACCSUM: begin
            res.val    = acc + opa;
            res.wr_acc = 1'b1;
         end
         MODE_BLT: res.taken = a_lt_b;
         MODE_BLE: res.taken = !b_lt_a;
         MODE_BEQ: res.taken = (opa == opb);
         MODE_BGT: res.taken = b_lt_a;
         MODE_BGE: res.taken = !a_lt_b;
         MODE_BNE: res.taken = (opa != opb);
         default: begin
            res.val = '0;
         end
      endcase
   end

endmodule

// ===== src/filter_bytecode_execute_unit_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// filter_bytecode_execute_unit_top
// Filter bytecode execute unit: register read, execute, writeback pipeline.
// ----------------------------------------------------------------------------
// Takes one instruction word per cycle while req_stall is low and returns one
// result word for each, in order. The pipeline has three stages: the first
// holds the word and its register and accumulator reads, forwards pending
// writes and executes; the second finishes the multiply and writes back; the
// last holds the result word. A multiply completes only in the writeback
// stage, so a word whose source fields name the register written by the
// multiply right before it waits in stage 1 until that multiply moves on;
// every other sequence runs at one word per cycle while rsp_stall is low.
// Accumulators read as zero after reset through per-slot valid bits, so no
// clearing pass is needed; register contents are undefined until written.
module filter_bytecode_execute_unit_top #(
   parameter int unsigned NUM_REGS = fbx_pkg::FBX_NUM_REGS,
   parameter int unsigned NUM_ACCS = fbx_pkg::FBX_NUM_ACCS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  fbx_pkg::fbx_req_type req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fbx_pkg::fbx_rsp_type rsp_data
);

   import fbx_pkg::*;

   localparam int unsigned RA_W = $clog2(NUM_REGS);
   localparam int unsigned AC_W = (NUM_ACCS > 1) ? $clog2(NUM_ACCS) : 1;

   // handshake
   logic accept;
   logic s1_adv;
   logic s2_adv;
   logic s3_take;
   logic hazard;

   // read addresses of the incoming word
   logic [RA_W-1:0] in_src_a;
   logic [RA_W-1:0] in_src_b;
   logic [RA_W-1:0] in_dest;
   logic [AC_W-1:0] in_slot;

   // stage 1
   logic            s1_vld_ff;
   logic            s1_vld_in;
   logic [4:0]      s1_mode_ff;
   logic [RA_W-1:0] s1_dest_ff;
   logic [AC_W-1:0] s1_slot_ff;
   logic [RA_W-1:0] s1_src_a_ff;
   logic [RA_W-1:0] s1_src_b_ff;
   logic [63:0]     s1_imm_ff;
   logic [63:0]     s1_col_ff;
   logic            s1_fix_ff;
   logic [63:0]     s1_opa_ff;
   logic [63:0]     s1_opb_ff;
   logic [63:0]     s1_acc_ff;

   logic [63:0] rf_rdata_a;
   logic [63:0] rf_rdata_b;
   logic [63:0] acc_rdata;
   logic [63:0] base_a;
   logic [63:0] base_b;
   logic [63:0] base_acc;
   logic [63:0] fwd_a;
   logic [63:0] fwd_b;
   logic [63:0] fwd_acc;

   fbx_alu_out_type alu_out;

   // stage 2
   logic            s2_vld_ff;
   logic            s2_vld_in;
   fbx_alu_out_type s2_alu_ff;
   logic [RA_W-1:0] s2_dest_ff;
   logic [AC_W-1:0] s2_slot_ff;
   logic [31:0]     s2_cross;
   logic [63:0]     s2_final;

   // stage 3
   logic            s3_vld_ff;
   logic            s3_vld_in;
   fbx_rsp_type     s3_rsp_ff;
   logic            s3_wr_reg_ff;
   logic            s3_wr_acc_ff;
   logic [RA_W-1:0] s3_dest_ff;
   logic [AC_W-1:0] s3_slot_ff;

   assign in_src_a = RA_W'(fbx_wrap_index(req_data.src_a_index, NUM_REGS));
   assign in_src_b = RA_W'(fbx_wrap_index(req_data.src_b_index, NUM_REGS));
   assign in_dest  = RA_W'(fbx_wrap_index(req_data.dest_index, NUM_REGS));
   assign in_slot  = AC_W'(fbx_wrap_index(req_data.dest_index, NUM_ACCS));

   // ---------------------------------------------------------------- control
   assign s3_take = !s3_vld_ff || !rsp_stall;
   assign s2_adv  = s2_vld_ff && s3_take;
   // multiply result is not ready before writeback
   assign hazard  = s1_vld_ff && s2_vld_ff && s2_alu_ff.is_mul &&
                    ((s2_dest_ff == s1_src_a_ff) || (s2_dest_ff == s1_src_b_ff));
   assign s1_adv  = s1_vld_ff && (!s2_vld_ff || s3_take) && !hazard;
   assign req_stall = s1_vld_ff && !s1_adv;
   assign accept  = req_valid && !req_stall;

   assign s1_vld_in = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_ff);
   assign s2_vld_in = s1_adv ? 1'b1 : (s2_adv ? 1'b0 : s2_vld_ff);
   assign s3_vld_in = s2_adv ? 1'b1 : (s3_take ? 1'b0 : s3_vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
         s3_vld_ff <= s3_vld_in;
      end
   end

   // --------------------------------------------------------------- memories
   fbx_regfile #(
      .DEPTH (NUM_REGS),
      .AW    (RA_W)
   ) u_regfile (
      .clock   (clock),
      .we      (s2_adv && s2_alu_ff.wr_reg),
      .waddr   (s2_dest_ff),
      .wdata   (s2_final),
      .re      (accept),
      .raddr_a (in_src_a),
      .raddr_b (in_src_b),
      .rdata_a (rf_rdata_a),
      .rdata_b (rf_rdata_b)
   );

   fbx_accfile #(
      .DEPTH (NUM_ACCS),
      .AW    (AC_W)
   ) u_accfile (
      .clock (clock),
      .reset (reset),
      .we    (s2_adv && s2_alu_ff.wr_acc),
      .waddr (s2_slot_ff),
      .wdata (s2_final),
      .re    (accept),
      .raddr (in_slot),
      .rdata (acc_rdata)
   );

   // ---------------------------------------------------------------- stage 1
   // once held, operands live in s1 registers, refreshed from the later stages
   assign base_a   = s1_fix_ff ? s1_opa_ff : rf_rdata_a;
   assign base_b   = s1_fix_ff ? s1_opb_ff : rf_rdata_b;
   assign base_acc = s1_fix_ff ? s1_acc_ff : acc_rdata;

   // the younger pending write wins
   always_comb begin
      if (s2_vld_ff && s2_alu_ff.wr_reg && (s2_dest_ff == s1_src_a_ff)) begin
         fwd_a = s2_alu_ff.val;
      end else if (s3_vld_ff && s3_wr_reg_ff && (s3_dest_ff == s1_src_a_ff)) begin
         fwd_a = s3_rsp_ff.written_value;
      end else begin
         fwd_a = base_a;
      end
      if (s2_vld_ff && s2_alu_ff.wr_reg && (s2_dest_ff == s1_src_b_ff)) begin
         fwd_b = s2_alu_ff.val;
      end else if (s3_vld_ff && s3_wr_reg_ff && (s3_dest_ff == s1_src_b_ff)) begin
         fwd_b = s3_rsp_ff.written_value;
      end else begin
         fwd_b = base_b;
      end
      if (s2_vld_ff && s2_alu_ff.wr_acc && (s2_slot_ff == s1_slot_ff)) begin
         fwd_acc = s2_alu_ff.val;
      end else if (s3_vld_ff && s3_wr_acc_ff && (s3_slot_ff == s1_slot_ff)) begin
         fwd_acc = s3_rsp_ff.written_value;
      end else begin
         fwd_acc = base_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_mode_ff  <= req_data.mode;
         s1_dest_ff  <= in_dest;
         s1_slot_ff  <= in_slot;
         s1_src_a_ff <= in_src_a;
         s1_src_b_ff <= in_src_b;
         s1_imm_ff   <= req_data.immediate;
         s1_col_ff   <= req_data.column_value;
         s1_fix_ff   <= 1'b0;
      end else if (s1_vld_ff && !s1_adv) begin
         s1_opa_ff <= fwd_a;
         s1_opb_ff <= fwd_b;
         s1_acc_ff <= fwd_acc;
         s1_fix_ff <= 1'b1;
      end
   end

   fbx_alu u_alu (
      .mode (s1_mode_ff),
      .opa  (fwd_a),
      .opb  (fwd_b),
      .acc  (fwd_acc),
      .imm  (s1_imm_ff),
      .col  (s1_col_ff),
      .res  (alu_out)
   );

   // ---------------------------------------------------------------- stage 2
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s2_alu_ff  <= alu_out;
         s2_dest_ff <= s1_dest_ff;
         s2_slot_ff <= s1_slot_ff;
      end
   end

   assign s2_cross = s2_alu_ff.pp_lh + s2_alu_ff.pp_hl;
   assign s2_final = s2_alu_ff.is_mul ? (s2_alu_ff.pp_ll + {s2_cross, 32'd0})
                                      : s2_alu_ff.val;

   // ---------------------------------------------------------------- stage 3
   always_ff @(posedge clock) begin
      if (s2_adv) begin
         s3_rsp_ff.branch_taken  <= s2_alu_ff.taken;
         s3_rsp_ff.written_value <= s2_final;
         s3_rsp_ff.did_write     <= s2_alu_ff.wr_reg || s2_alu_ff.wr_acc;
         s3_wr_reg_ff            <= s2_alu_ff.wr_reg;
         s3_wr_acc_ff            <= s2_alu_ff.wr_acc;
         s3_dest_ff              <= s2_dest_ff;
         s3_slot_ff              <= s2_slot_ff;
      end
   end

   assign rsp_valid = s3_vld_ff;
   assign rsp_data  = s3_rsp_ff;

   // ------------------------------------------------------------- assertions
   a_mul_interlock: assert property (@(posedge clock) disable iff (reset)
      hazard |-> !s1_adv && req_stall)
      else $error("dependent word left stage 1 behind a pending multiply");

   a_branch_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.branch_taken |->
         !rsp_data.did_write && (rsp_data.written_value == 64'sd0))
      else $error("taken branch reported a write");

   a_one_target: assert property (@(posedge clock) disable iff (reset)
      s2_vld_ff |-> !(s2_alu_ff.wr_reg && s2_alu_ff.wr_acc))
      else $error("word writes both register and accumulator");

   a_writeback_shows: assert property (@(posedge clock) disable iff (reset)
      s2_adv |=> rsp_valid && (rsp_data.written_value == $past(s2_final)))
      else $error("written value lost between writeback and result");

endmodule
